[sv/cusi_pkg.sv]
// shared constants and codes for the cubic sample interpolator
package cusi_pkg;

  localparam int DEF_STORE_DEPTH = 4096;
  localparam int DEF_SAMPLE_BITS = 16;

  localparam int TIME_W  = 32;
  localparam int FRAC_W  = 16;
  localparam int IDX_W   = 12;
  localparam int VAL_W   = 16;
  localparam int CNT_W   = 13;
  localparam int OUT_W   = 18;
  localparam int CFG_IDX_W = 2;

  localparam int OUT_MAX = 131071;
  localparam int OUT_MIN = -131072;

  localparam logic [CFG_IDX_W-1:0] CFG_COUNT    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL = 2'd1;

  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  localparam logic [CNT_W-1:0]  COUNT_RESET    = 13'd2;
  localparam logic [TIME_W-1:0] INTERVAL_RESET = 32'd65536;

endpackage

[sv/cusi_div.sv]
// pipelined restoring divider: integer quotient, remainder flag and Q0.16 fraction
module cusi_div #(
  parameter int TAG_W = 29
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      adv,
  input  logic                      in_v,
  input  logic [cusi_pkg::TIME_W-1:0] in_time,
  input  logic [TAG_W-1:0]          in_tag,
  input  logic [cusi_pkg::TIME_W-1:0] dt,
  output logic                      out_v,
  output logic [cusi_pkg::TIME_W+cusi_pkg::FRAC_W-1:0] out_quo,
  output logic                      out_rnz,
  output logic [TAG_W-1:0]          out_tag
);
  import cusi_pkg::*;

  localparam int STEPS = TIME_W + FRAC_W;

  logic [STEPS:0]     v;
  logic [STEPS:0]     rnz;
  logic [TIME_W-1:0]  rem [0:STEPS];
  logic [STEPS-1:0]   quo [0:STEPS];
  logic [TIME_W-1:0]  tm  [0:STEPS];
  logic [TAG_W-1:0]   tag [0:STEPS];

  // stage zero is the input transaction itself
  assign v[0]   = in_v;
  assign rnz[0] = 1'b0;
  assign rem[0] = '0;
  assign quo[0] = '0;
  assign tm[0]  = in_time;
  assign tag[0] = in_tag;

  // one quotient bit per stage, fraction bits shift in zeros
  for (genvar k = 0; k < STEPS; k++) begin : g_step
    logic              bit_in;
    logic [TIME_W:0]   trial;
    logic [TIME_W:0]   diff;
    logic              ge;
    logic [TIME_W-1:0] rem_n;

    if (k < TIME_W) begin : g_int
      assign bit_in = tm[k][TIME_W-1-k];
    end else begin : g_frac
      assign bit_in = 1'b0;
    end

    assign trial = {rem[k], bit_in};
    assign ge    = trial >= {1'b0, dt};
    assign diff  = trial - {1'b0, dt};
    assign rem_n = ge ? diff[TIME_W-1:0] : trial[TIME_W-1:0];

    always_ff @(posedge clk) begin
      if (rst) begin
        v[k+1] <= 1'b0;
      end else if (adv) begin
        v[k+1] <= v[k];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        rem[k+1] <= rem_n;
        quo[k+1] <= {quo[k][STEPS-2:0], ge};
        tm[k+1]  <= tm[k];
        tag[k+1] <= tag[k];
        if (k == TIME_W - 1) begin
          rnz[k+1] <= rem_n != '0;
        end else begin
          rnz[k+1] <= rnz[k];
        end
      end
    end
  end

  assign out_v   = v[STEPS];
  assign out_quo = quo[STEPS];
  assign out_rnz = rnz[STEPS];
  assign out_tag = tag[STEPS];

endmodule

[sv/cubic_sample_interpolator_top.sv]
// top level of the cubic sample interpolator
// Usage:
//   Input stream s_*: s_tuser is func (0 write sample, 1 query). Writes store
//   sample_value at sample_index and give no result; queries give one result.
//   Output stream m_*: m_tdata carries the rounded interpolation, m_tuser the
//   status flag (1 when the time lies past the last loaded sample).
//   Config channel cfg_*: index 0 sample_count, index 1 sample_interval;
//   always ready; the user must write it only while the block is idle (not enforced).
// Pipeline:
//   one transaction accepted per cycle while the output is not stalled; a query
//   passes through the 48-stage divider (32 quotient bits plus 16 fraction
//   bits, one per stage), then address, store read, coefficient and six Horner
//   stages, and the output register before its result shows on m_tvalid.
//   Four copies of the sample store give the four neighbour reads per cycle.
// Reset:
//   rst empties the pipeline and restores sample_count 2 and interval 1.0;
//   the sample store is not cleared and must be written before it is read.
// Stall:
//   when the output register holds a result that is not taken, the whole
//   pipeline holds and s_tready drops; nothing is lost or repeated.
module cubic_sample_interpolator_top #(
  parameter int STORE_DEPTH = cusi_pkg::DEF_STORE_DEPTH,
  parameter int SAMPLE_BITS = cusi_pkg::DEF_SAMPLE_BITS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // sample_index[11:0], sample_value[27:12], query_time[59:28]
  input  logic        s_tuser,   // func
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // interpolated[17:0]
  output logic        m_tuser,   // status
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [cusi_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0] cfg_data
);
  import cusi_pkg::*;

  localparam int ADDR_W = $clog2(STORE_DEPTH);
  localparam int SB     = SAMPLE_BITS;
  localparam int CW     = SB + 4;
  localparam int HW     = SB + 14;
  localparam int PW     = HW + FRAC_W + 1;
  localparam int TAG_W  = 1 + IDX_W + VAL_W;
  localparam int QW     = TIME_W + FRAC_W;

  typedef struct packed {
    logic                 past;
    logic                 exact;
    logic [FRAC_W-1:0]    u;
    logic signed [CW-1:0] a0;
    logic signed [CW-1:0] a1;
    logic signed [CW-1:0] a2;
    logic signed [SB-1:0] p1;
  } ctx_t;

  // configuration registers
  logic [CNT_W-1:0]  sample_count;
  logic [TIME_W-1:0] sample_interval;
  logic [TIME_W-1:0] dtc;
  logic [31:0]       cnt_eff;
  logic [31:0]       last32;
  logic [ADDR_W-1:0] last;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_count    <= COUNT_RESET;
      sample_interval <= INTERVAL_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_COUNT:    sample_count    <= cfg_data[CNT_W-1:0];
        CFG_INTERVAL: sample_interval <= cfg_data;
        default: ;
      endcase
    end
  end

  // effective interval and sample count
  always_comb begin
    dtc = (sample_interval == '0) ? 32'd1 : sample_interval;
    if (sample_count < CNT_W'(2)) begin
      cnt_eff = 32'd2;
    end else if (32'(sample_count) > 32'(STORE_DEPTH)) begin
      cnt_eff = 32'(STORE_DEPTH);
    end else begin
      cnt_eff = 32'(sample_count);
    end
    last32 = cnt_eff - 32'd1;
    last   = last32[ADDR_W-1:0];
  end

  // pipeline advance: the output register is the only place that can stall
  logic out_v;
  logic adv;
  assign adv      = !out_v || m_tready;
  assign s_tready = adv;

  // divider
  logic              d_v;
  logic [QW-1:0]     d_quo;
  logic              d_rnz;
  logic [TAG_W-1:0]  d_tag;

  cusi_div #(.TAG_W(TAG_W)) u_div (
    .clk     (clk),
    .rst     (rst),
    .adv     (adv),
    .in_v    (s_tvalid),
    .in_time (s_tdata[59:28]),
    .in_tag  ({s_tuser, s_tdata[27:12], s_tdata[11:0]}),
    .dt      (dtc),
    .out_v   (d_v),
    .out_quo (d_quo),
    .out_rnz (d_rnz),
    .out_tag (d_tag)
  );

  // address stage: clamp neighbours and classify the query
  logic [TIME_W-1:0] dq;
  logic [ADDR_W-1:0] qa;
  logic              past_n;
  logic [ADDR_W-1:0] addr_n [4];
  logic [IDX_W-1:0]  widx_in;
  logic [VAL_W-1:0]  wval_in;

  assign dq      = d_quo[QW-1:FRAC_W];
  assign qa      = dq[ADDR_W-1:0];
  assign widx_in = d_tag[IDX_W-1:0];
  assign wval_in = d_tag[IDX_W+VAL_W-1:IDX_W];

  always_comb begin
    past_n = (dq > last32) || ((dq == last32) && d_rnz);
    addr_n[1] = past_n ? last : qa;
    addr_n[0] = (qa == '0) ? '0 : qa - ADDR_W'(1);
    addr_n[2] = qa + ADDR_W'(1);
    addr_n[3] = (({1'b0, dq} + 33'd2) > {1'b0, last32}) ? last : qa + ADDR_W'(2);
  end

  logic              a_v;
  logic              a_isq;
  logic              a_wen;
  logic [ADDR_W-1:0] a_widx;
  logic [SB-1:0]     a_wval;
  logic [ADDR_W-1:0] a_addr [4];
  logic [FRAC_W-1:0] a_u;
  logic              a_past;
  logic              a_exact;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_v <= 1'b0;
    end else if (adv) begin
      a_v <= d_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_isq   <= d_tag[TAG_W-1] == FUNC_QUERY;
      a_wen   <= 32'(widx_in) < 32'(STORE_DEPTH);
      a_widx  <= ADDR_W'(widx_in);
      a_wval  <= SB'(32'($signed(wval_in)));
      a_addr  <= addr_n;
      a_u     <= d_quo[FRAC_W-1:0];
      a_past  <= past_n;
      a_exact <= !d_rnz;
    end
  end

  // store read stage: four copies, each written by every in-range sample write
  logic              m_v;
  logic              m_isq;
  logic [FRAC_W-1:0] m_u;
  logic              m_past;
  logic              m_exact;
  logic [SB-1:0]     m_p [4];

  for (genvar j = 0; j < 4; j++) begin : g_store
    logic [SB-1:0] mem [0:STORE_DEPTH-1];

    always_ff @(posedge clk) begin
      if (adv) begin
        if (a_v && !a_isq && a_wen) begin
          mem[a_widx] <= a_wval;
        end
        m_p[j] <= mem[a_addr[j]];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_v <= 1'b0;
    end else if (adv) begin
      m_v <= a_v && a_isq;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_isq   <= a_isq;
      m_u     <= a_u;
      m_past  <= a_past;
      m_exact <= a_exact;
    end
  end

  // coefficient stage of 2*p(u)
  logic signed [CW-1:0] p0e, p1e, p2e, p3e;
  logic                 c_v;
  logic signed [CW-1:0] c_a3;
  ctx_t                 c_ctx;

  assign p0e = CW'($signed(m_p[0]));
  assign p1e = CW'($signed(m_p[1]));
  assign p2e = CW'($signed(m_p[2]));
  assign p3e = CW'($signed(m_p[3]));

  always_ff @(posedge clk) begin
    if (rst) begin
      c_v <= 1'b0;
    end else if (adv) begin
      c_v <= m_v && m_isq;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c_ctx.past  <= m_past;
      c_ctx.exact <= m_exact;
      c_ctx.u     <= m_u;
      c_ctx.p1    <= $signed(m_p[1]);
      c_ctx.a0    <= p1e <<< 1;
      c_ctx.a1    <= p2e - p0e;
      c_ctx.a2    <= (p0e <<< 1) - (p1e <<< 2) - p1e + (p2e <<< 2) - p3e;
      c_a3        <= (p1e <<< 1) + p1e - (p2e <<< 1) - p2e + p3e - p0e;
    end
  end

  // horner stages: multiply, then shift and add, three times
  logic [6:0]           hv;
  ctx_t                 hc [0:6];
  logic signed [HW-1:0] hh [0:3];
  logic signed [PW-1:0] hp [0:2];

  assign hv[0] = c_v;
  assign hc[0] = c_ctx;
  assign hh[0] = HW'(c_a3) <<< 8;

  for (genvar j = 0; j < 3; j++) begin : g_horner
    logic signed [CW-1:0] ak;

    if (j == 0) begin : g_a2
      assign ak = hc[2*j+1].a2;
    end else if (j == 1) begin : g_a1
      assign ak = hc[2*j+1].a1;
    end else begin : g_a0
      assign ak = hc[2*j+1].a0;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        hv[2*j+1] <= 1'b0;
        hv[2*j+2] <= 1'b0;
      end else if (adv) begin
        hv[2*j+1] <= hv[2*j];
        hv[2*j+2] <= hv[2*j+1];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        hc[2*j+1] <= hc[2*j];
        hp[j]     <= hh[j] * $signed({1'b0, hc[2*j].u});
        hc[2*j+2] <= hc[2*j+1];
        hh[j+1]   <= HW'(hp[j] >>> FRAC_W) + (HW'(ak) <<< 8);
      end
    end
  end

  // rounding, special cases and saturation into the output register
  localparam logic signed [HW:0] RMAX = (HW+1)'(OUT_MAX);
  localparam logic signed [HW:0] RMIN = (HW+1)'(OUT_MIN);

  logic signed [HW:0]    rs;
  logic signed [OUT_W-1:0] rsat;
  logic [OUT_W-1:0]      out_val;
  logic                  out_status;

  always_comb begin
    if (hc[6].past || hc[6].exact) begin
      rs = (HW+1)'(hc[6].p1);
    end else begin
      rs = ((HW+1)'(hh[3]) + (HW+1)'(256)) >>> 9;
    end
    if (rs > RMAX) begin
      rsat = OUT_W'(OUT_MAX);
    end else if (rs < RMIN) begin
      rsat = OUT_W'(OUT_MIN);
    end else begin
      rsat = rs[OUT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
    end else if (adv) begin
      out_v <= hv[6];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_val    <= rsat;
      out_status <= hc[6].past;
    end
  end

  assign m_tvalid = out_v;
  assign m_tdata  = {6'b0, out_val};
  assign m_tuser  = out_status;

`ifndef SYNTHESIS
  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    cnt_eff >= 32'd2 && cnt_eff <= 32'(STORE_DEPTH))
    else $error("effective sample count out of range");

  a_nbr_in_range: assert property (@(posedge clk) disable iff (rst)
    a_v && a_isq && !a_past |-> a_addr[1] <= last && a_addr[3] <= last)
    else $error("neighbour address beyond last sample");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    !adv |=> out_v)
    else $error("stalled result dropped");

  a_ready_link: assert property (@(posedge clk) disable iff (rst)
    s_tready == (!m_tvalid || m_tready))
    else $error("input ready not tied to output stall");
`endif

endmodule
